/* rtl/wmie_pkg.sv */
// ============================================================================
// wmie_pkg
// Shared types and constants of the word machine instruction executor.
// ============================================================================
package wmie_pkg;

   // Machine size.
   localparam int unsigned MEM_WORDS   = 100;
   localparam int unsigned BLOCK_WORDS = 10;
   localparam int unsigned ADDR_W      = 7;
   localparam int unsigned BLK_W       = 4;

   // Request operation codes.
   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_LOAD  = 3'd1;
   localparam logic [2:0] OP_START = 3'd2;
   localparam logic [2:0] OP_STEP  = 3'd3;
   localparam logic [2:0] OP_CARD  = 3'd4;

   // Result status codes.
   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_CARD    = 3'd1;
   localparam logic [2:0] STAT_PRINT   = 3'd2;
   localparam logic [2:0] STAT_HALT    = 3'd3;
   localparam logic [2:0] STAT_BADOP   = 3'd4;
   localparam logic [2:0] STAT_BADADDR = 3'd5;

   // Character codes.
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_H     = 8'h48;
   localparam logic [7:0] CHAR_G     = 8'h47;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_L     = 8'h4C;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_C     = 8'h43;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_T     = 8'h54;

   localparam logic [31:0] HASH_WORD = 32'h2323_2323;

   // One printed word.
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  count;
   } print_type;

   // Keeps the characters before the first hash and turns newlines into spaces.
   function automatic print_type fmt_print(input logic [31:0] w);
      print_type  r;
      logic [7:0] ch;
      logic       stop;
      r.word  = '0;
      r.count = '0;
      stop    = 1'b0;
      for (int p = 0; p < 4; p++) begin
         ch = w[31-8*p -: 8];
         if (ch == CHAR_HASH) begin
            stop = 1'b1;
         end
         if (!stop) begin
            if (ch == CHAR_NL) begin
               ch = CHAR_SPACE;
            end
            r.word[31-8*p -: 8] = ch;
            r.count = r.count + 3'd1;
         end
      end
      return r;
   endfunction

endpackage

/* rtl/wmie_ram.sv */
// ============================================================================
// wmie_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
module wmie_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/word_machine_instruction_executor_top.sv */
// ============================================================================
// word_machine_instruction_executor_top
// Small word machine: 100 four-character words, register R, compare flag and
// instruction counter, driven by clear, load, start, step and card requests.
// ============================================================================
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_stall    op, word, char_count
//   rsp_      out         rsp_valid/rsp_stall    status, out_word, out_count, last
//
// Clear, load, start and ignored requests go straight to the emit state, as does
// a step that is refused at once; a step that reads memory goes through decode
// (LR and CR also through an operand state), as the single memory read port is registered.
// PD reads each block word and then hands it out, ten words in all, waiting on any output stall.
// A card word is read, then merged and written back, then its result is emitted.
// Reset is synchronous and clears per-word valid bits, so memory reads as hash
// at once; there is no clearing pass. req_stall is high while a request is in
// work; a finished result waits in the output register and stalls the next.
module word_machine_instruction_executor_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_word,
   input  logic [2:0]  req_char_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_out_word,
   output logic [2:0]  rsp_out_count,
   output logic        rsp_last
);
   import wmie_pkg::*;

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EMIT   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_OPEX   = 3'd3;
   localparam logic [2:0] S_CARD   = 3'd4;
   localparam logic [2:0] S_PRD    = 3'd5;
   localparam logic [2:0] S_PRW    = 3'd6;

   localparam logic [ADDR_W-1:0] MEM_END   = ADDR_W'(MEM_WORDS);
   localparam logic [ADDR_W-1:0] BLK_LIMIT = ADDR_W'(MEM_WORDS - BLOCK_WORDS);
   localparam logic [BLK_W-1:0]  BLK_LAST  = BLK_W'(BLOCK_WORDS - 1);
   localparam logic [BLK_W-1:0]  BLK_FULL  = BLK_W'(BLOCK_WORDS);

   logic [2:0]           state_ff, state_in;
   logic [ADDR_W-1:0]    ic_ff, ic_in;
   logic [31:0]          greg_ff, greg_in;
   logic                 flag_ff, flag_in;
   logic [ADDR_W-1:0]    load_ptr_ff, load_ptr_in;
   logic [ADDR_W-1:0]    card_ptr_ff, card_ptr_in;
   logic [BLK_W-1:0]     card_left_ff, card_left_in;
   logic                 halted_ff, halted_in;
   logic [MEM_WORDS-1:0] word_valid_ff, word_valid_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [2:0]           pend_ff, pend_in;
   logic [BLK_W-1:0]     blk_ff, blk_in;
   logic [ADDR_W-1:0]    opaddr_ff, opaddr_in;
   logic                 op_cr_ff, op_cr_in;
   logic [31:0]          card_word_ff, card_word_in;
   logic [2:0]           card_cnt_ff, card_cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [31:0]          rsp_word_ff, rsp_word_in;
   logic [2:0]           rsp_count_ff, rsp_count_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 wr_en, rd_en;
   logic [ADDR_W-1:0]    wr_addr, rd_addr;
   logic [31:0]          wr_data, rd_data, mem_word;
   logic                 req_accept, out_free, out_load;
   logic [7:0]           c0, c1, d0, d1;
   logic [3:0]           d0n, d1n;
   logic                 addr_ok, opcode_ok;
   logic [ADDR_W-1:0]    loc;
   logic [31:0]          merged;
   logic [BLK_W-1:0]     left_dec;
   print_type            pr;

   // State memory.
   wmie_ram #(
      .WIDTH(32),
      .DEPTH(MEM_WORDS)
   ) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // A word never written since clear reads as all hash.
   assign mem_word = rd_valid_ff ? rd_data : HASH_WORD;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Instruction fields and address decode.
   assign c0  = mem_word[31:24];
   assign c1  = mem_word[23:16];
   assign d0  = mem_word[15:8];
   assign d1  = mem_word[7:0];
   assign d0n = 4'(d0 - CHAR_ZERO);
   assign d1n = 4'(d1 - CHAR_ZERO);
   assign addr_ok = (d0 >= CHAR_ZERO) && (d0 <= CHAR_NINE) &&
                    (d1 >= CHAR_ZERO) && (d1 <= CHAR_NINE);
   assign loc = ({3'b000, d0n} << 3) + ({3'b000, d0n} << 1) + {3'b000, d1n};
   assign opcode_ok = (c0 == CHAR_G && c1 == CHAR_D) || (c0 == CHAR_P && c1 == CHAR_D) ||
                      (c0 == CHAR_L && c1 == CHAR_R) || (c0 == CHAR_S && c1 == CHAR_R) ||
                      (c0 == CHAR_C && c1 == CHAR_R) || (c0 == CHAR_B && c1 == CHAR_T);

   // Card merge: the leading characters come from the card word.
   always_comb begin
      merged = mem_word;
      for (int p = 0; p < 4; p++) begin
         if (3'(p) < card_cnt_ff) begin
            merged[31-8*p -: 8] = card_word_ff[31-8*p -: 8];
         end
      end
      left_dec = (card_cnt_ff < 3'd4) ? '0 : card_left_ff - 4'd1;
   end

   assign pr = fmt_print(mem_word);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      ic_in         = ic_ff;
      greg_in       = greg_ff;
      flag_in       = flag_ff;
      load_ptr_in   = load_ptr_ff;
      card_ptr_in   = card_ptr_ff;
      card_left_in  = card_left_ff;
      halted_in     = halted_ff;
      word_valid_in = word_valid_ff;
      rd_valid_in   = rd_valid_ff;
      pend_in       = pend_ff;
      blk_in        = blk_ff;
      opaddr_in     = opaddr_ff;
      op_cr_in      = op_cr_ff;
      card_word_in  = card_word_ff;
      card_cnt_in   = card_cnt_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = greg_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      out_load      = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_word_in   = '0;
      rsp_count_in  = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               pend_in  = STAT_OK;
               state_in = S_EMIT;
               unique case (req_op)
                  OP_CLEAR: begin
                     word_valid_in = '0;
                     load_ptr_in   = '0;
                     halted_in     = 1'b1;
                     card_left_in  = '0;
                  end
                  OP_LOAD: begin
                     if (load_ptr_ff < MEM_END) begin
                        wr_en       = 1'b1;
                        wr_addr     = load_ptr_ff;
                        wr_data     = req_word;
                        word_valid_in[load_ptr_ff] = 1'b1;
                        load_ptr_in = load_ptr_ff + 7'd1;
                     end
                  end
                  OP_START: begin
                     ic_in        = '0;
                     halted_in    = 1'b0;
                     card_left_in = '0;
                  end
                  OP_STEP: begin
                     priority if (halted_ff) begin
                        pend_in = STAT_HALT;
                     end else if (card_left_ff != '0) begin
                        pend_in = STAT_CARD;
                     end else if (ic_ff >= MEM_END) begin
                        halted_in = 1'b1;
                        pend_in   = STAT_BADADDR;
                     end else begin
                        rd_en       = 1'b1;
                        rd_addr     = ic_ff;
                        rd_valid_in = word_valid_ff[ic_ff];
                        state_in    = S_DECODE;
                     end
                  end
                  OP_CARD: begin
                     if (card_left_ff == '0 || card_ptr_ff >= MEM_END) begin
                        card_left_in = '0;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = card_ptr_ff;
                        rd_valid_in  = word_valid_ff[card_ptr_ff];
                        card_word_in = req_word;
                        card_cnt_in  = (req_char_count > 3'd4) ? 3'd4 : req_char_count;
                        state_in     = S_CARD;
                     end
                  end
                  default: begin
                     pend_in = STAT_OK;
                  end
               endcase
            end
         end

         // Single result waits here for the output register.
         S_EMIT: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_status_in = pend_ff;
               state_in      = S_IDLE;
            end
         end

         // Instruction word has arrived from memory.
         S_DECODE: begin
            ic_in    = ic_ff + 7'd1;
            pend_in  = STAT_OK;
            state_in = S_EMIT;
            priority if (c0 == CHAR_H) begin
               halted_in = 1'b1;
               pend_in   = STAT_HALT;
            end else if (!opcode_ok) begin
               halted_in = 1'b1;
               pend_in   = STAT_BADOP;
            end else if (!addr_ok || (c1 == CHAR_D && loc > BLK_LIMIT)) begin
               halted_in = 1'b1;
               pend_in   = STAT_BADADDR;
            end else if (c0 == CHAR_G) begin
               card_ptr_in  = loc;
               card_left_in = BLK_FULL;
               pend_in      = STAT_CARD;
            end else if (c0 == CHAR_P) begin
               opaddr_in = loc;
               blk_in    = '0;
               state_in  = S_PRD;
            end else if (c0 == CHAR_L || c0 == CHAR_C) begin
               rd_en       = 1'b1;
               rd_addr     = loc;
               rd_valid_in = word_valid_ff[loc];
               op_cr_in    = (c0 == CHAR_C);
               state_in    = S_OPEX;
            end else if (c0 == CHAR_S) begin
               wr_en   = 1'b1;
               wr_addr = loc;
               wr_data = greg_ff;
               word_valid_in[loc] = 1'b1;
            end else begin
               if (flag_ff) begin
                  ic_in = loc;
               end
            end
         end

         // Operand of LR or CR has arrived.
         S_OPEX: begin
            if (op_cr_ff) begin
               flag_in = (greg_ff == mem_word);
            end else begin
               greg_in = mem_word;
            end
            pend_in  = STAT_OK;
            state_in = S_EMIT;
         end

         // Card word merged into the block word and written back.
         S_CARD: begin
            wr_en        = 1'b1;
            wr_addr      = card_ptr_ff;
            wr_data      = merged;
            word_valid_in[card_ptr_ff] = 1'b1;
            card_ptr_in  = card_ptr_ff + 7'd1;
            card_left_in = left_dec;
            pend_in      = (left_dec != '0) ? STAT_CARD : STAT_OK;
            state_in     = S_EMIT;
         end

         // Print: read the next block word.
         S_PRD: begin
            rd_en       = 1'b1;
            rd_addr     = opaddr_ff;
            rd_valid_in = word_valid_ff[opaddr_ff];
            state_in    = S_PRW;
         end

         // Print: hand the word to the output register.
         S_PRW: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_status_in = STAT_PRINT;
               rsp_word_in   = pr.word;
               rsp_count_in  = pr.count;
               rsp_last_in   = (blk_ff == BLK_LAST);
               if (blk_ff == BLK_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  blk_in    = blk_ff + 4'd1;
                  opaddr_in = opaddr_ff + 7'd1;
                  state_in  = S_PRD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register valid.
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ic_ff         <= '0;
         greg_ff       <= '0;
         flag_ff       <= 1'b0;
         load_ptr_ff   <= '0;
         card_ptr_ff   <= '0;
         card_left_ff  <= '0;
         halted_ff     <= 1'b1;
         word_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ic_ff         <= ic_in;
         greg_ff       <= greg_in;
         flag_ff       <= flag_in;
         load_ptr_ff   <= load_ptr_in;
         card_ptr_ff   <= card_ptr_in;
         card_left_ff  <= card_left_in;
         halted_ff     <= halted_in;
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_valid_ff  <= rd_valid_in;
      pend_ff      <= pend_in;
      blk_ff       <= blk_in;
      opaddr_ff    <= opaddr_in;
      op_cr_ff     <= op_cr_in;
      card_word_ff <= card_word_in;
      card_cnt_ff  <= card_cnt_in;
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_word_ff   <= rsp_word_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_word  = rsp_word_ff;
   assign rsp_out_count = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

   // Checks.
   a_card_left_range: assert property (@(posedge clock) disable iff (reset)
      card_left_ff <= BLK_FULL)
      else $error("card word count above block size");

   a_ic_range: assert property (@(posedge clock) disable iff (reset)
      ic_ff <= MEM_END)
      else $error("instruction counter past memory end");

   a_clear_effect: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op == OP_CLEAR) |=>
         (halted_ff && card_left_ff == '0 && load_ptr_ff == '0))
      else $error("clear job did not halt and reset pointers");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STAT_PRINT) |-> rsp_last_ff)
      else $error("non-print result without last");

endmodule
